@@ rtl/modexp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants, types and state encodings for the modular
// exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned BASE_W  = 32;
  localparam int unsigned EXPIN_W = 63;
  localparam int unsigned RES_W   = 30;

  // number of exponent bits that are scanned, 1 to 64
  localparam int unsigned EXP_WIDTH = 63;

  localparam logic [RES_W-1:0] PRIME_MOD = 30'd998244353;
  localparam logic [31:0]      ONE_P     = {2'b00, PRIME_MOD};
  localparam logic [31:0]      TWO_P     = {1'b0, PRIME_MOD, 1'b0};

  // barrett factor floor(2^60 / p)
  localparam logic [61:0] MU_FULL = (62'd1 << 60) / {32'd0, PRIME_MOD};
  localparam logic [30:0] MU      = MU_FULL[30:0];

  typedef enum logic [1:0] {
    MM_REDUCE = 2'd0,
    MM_SQUARE = 2'd1,
    MM_MUL    = 2'd2
  } mm_op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_REDUCE = 3'd1,
    ST_WAIT   = 3'd2,
    ST_MUL    = 3'd3,
    ST_SQUARE = 3'd4,
    ST_DONE   = 3'd5
  } ctrl_state_e;

  typedef struct packed {
    logic   load;
    logic   issue;
    mm_op_e op;
    logic   shift;
    logic   capture;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic exp_zero;
    logic exp_bit0;
    logic exp_rest_zero;
  } dp_status_t;

endpackage : modexp_pkg
`default_nettype wire

@@ rtl/modexp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_in_if / modexp_out_if
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface modexp_in_if;
  import modexp_pkg::*;

  logic               valid;
  logic               ready;
  logic [BASE_W-1:0]  base;
  logic [EXPIN_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);

endinterface : modexp_in_if

interface modexp_out_if;
  import modexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);

endinterface : modexp_out_if
`default_nettype wire

@@ rtl/modular_exponentiation_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One operand beat is processed at a time. The loop through the 3-stage modular
//   multiplier sets the cost per bit; a new beat is taken while a result waits.
// reset: asynchronous active low, returns to idle with no result pending
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base^exponent mod 998244353 by right-to-left square-and-multiply
// on one shared pipelined modular multiplier.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  modexp_in_if.sink     in_i,
  modexp_out_if.source  out_o
);
  import modexp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  modexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  modexp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .base_i     (in_i.base),
    .exponent_i (in_i.exponent),
    .power_o    (out_o.power)
  );

endmodule : modular_exponentiation_core
`default_nettype wire

@@ rtl/modexp_modmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_modmul
// Pipelined multiplier modulo 998244353 with barrett reduction. Three
// register stages, final correction on the output. One issue per cycle.
// ----------------------------------------------------------------------------
module modexp_modmul (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        vld_i,
  input  wire modexp_pkg::mm_op_e          op_i,
  input  wire logic [31:0]                 a_i,
  input  wire logic [modexp_pkg::RES_W-1:0] b_i,
  output logic                             vld_o,
  output modexp_pkg::mm_op_e               op_o,
  output logic [modexp_pkg::RES_W-1:0]     res_o,
  output logic                             busy_o
);
  import modexp_pkg::*;

  logic        v1_q, v2_q, v3_q;
  mm_op_e      op1_q, op2_q, op3_q;
  logic [59:0] prod_q;
  logic [61:0] est_q;
  logic [31:0] low_q;
  logic [31:0] rem_q;

  logic [61:0] prod_full;
  logic [61:0] est_full;
  logic [30:0] quot;
  logic [60:0] qp_full;
  logic [31:0] corr;

  assign prod_full = 62'(a_i) * 62'(b_i);
  assign est_full  = 62'(prod_q[59:29]) * 62'(MU);
  assign quot      = est_q[61:31];
  assign qp_full   = 61'(quot) * 61'(PRIME_MOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= op_i;
    op2_q  <= op1_q;
    op3_q  <= op2_q;
    prod_q <= prod_full[59:0];
    est_q  <= est_full;
    low_q  <= prod_q[31:0];
    rem_q  <= low_q - qp_full[31:0];
  end

  // remainder estimate is below 3p
  always_comb begin
    if (rem_q >= TWO_P) begin
      corr = rem_q - TWO_P;
    end else if (rem_q >= ONE_P) begin
      corr = rem_q - ONE_P;
    end else begin
      corr = rem_q;
    end
  end

  assign res_o  = corr[RES_W-1:0];
  assign vld_o  = v3_q;
  assign op_o   = op3_q;
  assign busy_o = v1_q | v2_q | v3_q;

endmodule : modexp_modmul
`default_nettype wire

@@ rtl/modexp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_datapath
// Operand, accumulator, square and exponent registers around the shared
// modular multiplier, plus the result register.
// ----------------------------------------------------------------------------
module modexp_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire modexp_pkg::dp_cmd_t           cmd_i,
  output modexp_pkg::dp_status_t             status_o,
  input  wire logic [modexp_pkg::BASE_W-1:0]  base_i,
  input  wire logic [modexp_pkg::EXPIN_W-1:0] exponent_i,
  output logic [modexp_pkg::RES_W-1:0]       power_o
);
  import modexp_pkg::*;

  logic [BASE_W-1:0]    base_q;
  logic [RES_W-1:0]     acc_q, acc_d;
  logic [RES_W-1:0]     sq_q, sq_d;
  logic [EXP_WIDTH-1:0] exp_q, exp_d;
  logic [RES_W-1:0]     power_q, power_d;
  logic [63:0]          exp_ext;

  logic [31:0]      mm_a;
  logic [RES_W-1:0] mm_b;
  logic             mm_vld;
  mm_op_e           mm_op;
  logic [RES_W-1:0] mm_res;
  logic             mm_busy;

  always_comb begin
    case (cmd_i.op)
      MM_REDUCE: begin
        mm_a = base_q;
        mm_b = RES_W'(1);
      end
      MM_SQUARE: begin
        mm_a = 32'(sq_q);
        mm_b = sq_q;
      end
      MM_MUL: begin
        mm_a = 32'(acc_q);
        mm_b = sq_q;
      end
      default: begin
        mm_a = 32'(acc_q);
        mm_b = sq_q;
      end
    endcase
  end

  modexp_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (cmd_i.issue),
    .op_i   (cmd_i.op),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .vld_o  (mm_vld),
    .op_o   (mm_op),
    .res_o  (mm_res),
    .busy_o (mm_busy)
  );

  assign exp_ext = 64'(exponent_i);

  always_comb begin
    acc_d   = acc_q;
    sq_d    = sq_q;
    exp_d   = exp_q;
    power_d = power_q;
    if (cmd_i.load) begin
      acc_d = RES_W'(1);
      exp_d = exp_ext[EXP_WIDTH-1:0];
    end else if (cmd_i.shift) begin
      exp_d = exp_q >> 1;
    end
    if (mm_vld) begin
      if (mm_op == MM_MUL) begin
        acc_d = mm_res;
      end else begin
        sq_d = mm_res;
      end
    end
    if (cmd_i.capture) begin
      power_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
    end
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    exp_q   <= exp_d;
    power_q <= power_d;
  end

  assign status_o.busy          = mm_busy;
  assign status_o.exp_zero      = (exp_q == '0);
  assign status_o.exp_bit0      = exp_q[0];
  assign status_o.exp_rest_zero = ((exp_q >> 1) == '0);
  assign power_o                = power_q;

endmodule : modexp_datapath
`default_nettype wire

@@ rtl/modexp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for right-to-left square-and-multiply: issues multiplier
// operations per exponent bit and manages the result beat.
// ----------------------------------------------------------------------------
module modexp_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output modexp_pkg::dp_cmd_t         cmd_o,
  input  wire modexp_pkg::dp_status_t status_i
);
  import modexp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_REDUCE;
      end
      ST_REDUCE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (!status_i.busy) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = status_i.exp_zero ? ST_DONE : ST_SQUARE;
      end
      ST_SQUARE: state_d = ST_WAIT;
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.issue   = 1'b0;
    cmd_o.op      = MM_MUL;
    cmd_o.shift   = 1'b0;
    cmd_o.capture = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_REDUCE: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = MM_REDUCE;
      end
      ST_MUL: begin
        cmd_o.issue = !status_i.exp_zero && status_i.exp_bit0;
        cmd_o.op    = MM_MUL;
      end
      ST_SQUARE: begin
        // last square is never used
        cmd_o.issue = !status_i.exp_rest_zero;
        cmd_o.op    = MM_SQUARE;
        cmd_o.shift = 1'b1;
      end
      ST_DONE: begin
        cmd_o.capture = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : modexp_ctrl
`default_nettype wire

@@ verif/modexp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_checker
// Watches the operand and result channels of the modular exponentiation core.
// For every accepted operand beat it computes base^exponent mod 998244353 by
// its own square-and-multiply loop and queues the value. Every accepted result
// beat is compared with the oldest queued value. Mismatches and results that
// arrive with nothing queued are counted, and the count is handed to the top.
// ----------------------------------------------------------------------------
module modexp_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  modexp_in_if  in_mon,
  modexp_out_if out_mon,
  output int    err_cnt_o,
  output int    pending_o
);
  import modexp_pkg::*;

  localparam logic [63:0] MODULUS = 64'(PRIME_MOD);

  logic [RES_W-1:0] power_q[$];
  int               beat_cnt;

  function automatic logic [RES_W-1:0] mod_power(logic [BASE_W-1:0]  base,
                                                 logic [EXPIN_W-1:0] exponent);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = {32'd0, base} % MODULUS;
    for (int i = 0; i < EXP_WIDTH; i++) begin
      if (i < EXPIN_W && exponent[i]) begin
        acc = (acc * sq) % MODULUS;
      end
      sq = (sq * sq) % MODULUS;
    end
    return acc[RES_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                 input logic [RES_W-1:0] want);
    $display("[%0t] mismatch at result beat %0d: %s, got %0d want %0d",
             $time, beat_cnt, what, got, want);
    err_cnt_o++;
  endtask

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
    beat_cnt  = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        power_q.push_back(mod_power(in_mon.base, in_mon.exponent));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (power_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", out_mon.power, '0);
        end else begin
          logic [RES_W-1:0] want;
          want = power_q.pop_front();
          if (out_mon.power !== want) begin
            report_mismatch("power", out_mon.power, want);
          end
        end
        beat_cnt++;
      end
    end
    pending_o = power_q.size();
  end

endmodule : modexp_checker

@@ verif/modular_exponentiation_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core_tb
// Drives operand beats into the modular exponentiation core: a directed set of
// corner cases (zero exponent, zero base, bases at and above the prime, full
// width exponents, bits at the top of the exponent) and then random operands
// of mixed exponent length, sent in bursts with random gaps while the result
// side stalls on its own pattern. Checking is done by modexp_checker.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_tb;
  import modexp_pkg::*;

  localparam int          RANDOM_BEATS = 1050;
  localparam logic [31:0] PRIME32      = 32'(PRIME_MOD);

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   pending;

  modexp_in_if  in_if ();
  modexp_out_if out_if ();

  modular_exponentiation_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  modexp_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side stall pattern
  int stall_mode;
  int stall_left;

  initial begin
    out_if.ready = 1'b0;
    stall_mode   = 0;
    stall_left   = 0;
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(1, 40) : $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      0, 1: begin
        out_if.ready <= 1'b1;
      end
      2: begin
        out_if.ready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_if.ready <= 1'b0;
      end
    endcase
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_operand(input logic [BASE_W-1:0] base,
                              input logic [EXPIN_W-1:0] exponent);
    in_if.valid    <= 1'b1;
    in_if.base     <= base;
    in_if.exponent <= exponent;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_if.valid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 3);
      1:       return PRIME32 + $urandom_range(0, 4) - 32'd2;
      2:       return {PRIME32[30:0], 1'b0} + $urandom_range(0, 4) - 32'd2;
      3:       return $urandom_range(0, 32'h3fff_ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EXPIN_W-1:0] pick_exponent();
    logic [63:0] raw;
    int          bits;
    raw  = {$urandom, $urandom};
    bits = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 63);
    if (bits < 64) begin
      raw = raw & ((64'd1 << bits) - 64'd1);
    end
    return raw[EXPIN_W-1:0];
  endfunction

  initial begin
    in_if.valid    = 1'b0;
    in_if.base     = '0;
    in_if.exponent = '0;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corner cases
    send_operand(32'd0, '0);
    send_operand(32'hffff_ffff, '0);
    send_operand(32'd0, 63'd1);
    send_operand(32'd0, {EXPIN_W{1'b1}});
    send_operand(32'd1, {EXPIN_W{1'b1}});
    send_operand(32'hffff_ffff, {EXPIN_W{1'b1}});
    send_operand(32'hffff_ffff, 63'd1);
    send_operand(PRIME32, 63'd5);
    send_operand(PRIME32 - 32'd1, 63'd3);
    send_operand(PRIME32 + 32'd1, 63'd1000);
    send_operand({PRIME32[30:0], 1'b0}, 63'd7);
    send_operand(32'd2, 63'd1);
    send_operand(32'd2, 63'd2);
    send_operand(32'd3, {1'b1, {(EXPIN_W-1){1'b0}}});
    send_operand(32'd12345, 63'(PRIME32 - 32'd1));
    send_operand(32'd12345, 63'(PRIME32 - 32'd2));
    send_operand(32'h8000_0000, 63'h2aaa_aaaa_aaaa_aaaa);
    send_operand(32'h5555_5555, 63'h5555_5555_5555_5555);
    pause_sender(3);

    // random operands in bursts
    for (int n = 0; n < RANDOM_BEATS; ) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < RANDOM_BEATS; k++) begin
        send_operand(pick_base(), pick_exponent());
        n++;
      end
      pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20));
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule : modular_exponentiation_core_tb
